>>> sv/vbnc_pkg.sv
package vbnc_pkg;

  // Field and register widths fixed by the interface.
  localparam int XW      = 9;
  localparam int YW      = 9;
  localparam int ZW      = 11;
  localparam int IDW     = 32;
  localparam int CNTW    = 4;
  localparam int PLANE_W = XW + YW;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 11;

  // Depth of the queues between the parts, and the width of their fill counts.
  localparam int FIFO_D  = 4;
  localparam int FIFO_CW = 3;

  localparam logic KIND_VOXEL = 1'b0;

  typedef enum logic [CFG_IW-1:0] {
    REG_X_SIZE      = 3'd0,
    REG_Y_SIZE      = 3'd1,
    REG_Z_SIZE      = 3'd2,
    REG_IGNORE_ZERO = 3'd3,
    REG_COUNT_OUTER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                  kind;
    logic signed [IDW-1:0] voxel_id;
  } in_item_t;

  typedef struct packed {
    logic [CNTW-1:0] boundary_count;
    logic            last_of_volume;
  } out_item_t;

  // Sizes are held already clamped to their legal ranges.
  typedef struct packed {
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [ZW-1:0] nz;
    logic          ignore_zero;
    logic          count_outer;
  } cfg_t;

  // One shift of the neighbor window; emit marks a shift that answers a voxel.
  typedef struct packed {
    logic           emit;
    logic           last;
    logic [IDW-1:0] id;
  } op_t;

  // Position of the answered voxel on the volume surface.
  typedef struct packed {
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
  } edge_flags_t;

endpackage

>>> sv/voxel_boundary_neighbor_count.sv
// Channel   Handshake            Payload
// input     in_push / in_full    in_item    (kind, voxel_id)
// result    out_pop / out_empty  out_item   (boundary_count, last_of_volume)
// config    cfg_we               cfg_index, cfg_data
//
// One request per cycle is taken while in_full is low; a voxel's result is released
// one plane later (x_size*y_size requests, or the whole volume when it is a single
// plane) and reaches the result ports through the op queue and count stage. A
// single-plane volume holds the input off after its last voxel until its extra shift
// is queued. Drain requests flush the last plane at one result per cycle while the
// queues have room. rst_n is synchronous; after reset and after each size write
// in_full stays high while the plane and volume products settle.
// The window is two plane stores and two row stores, each shifted once per op queue
// entry: per request that stores or answers a voxel, plus a single-plane extra shift.
module voxel_boundary_neighbor_count import vbnc_pkg::*; #(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  in_item_t            in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  localparam int NXM     = (MAX_X < 511) ? MAX_X : 511;
  localparam int NYM     = (MAX_Y < 511) ? MAX_Y : 511;
  localparam int NZM     = (MAX_Z < 2047) ? MAX_Z : 2047;
  localparam int POS_W   = $clog2(NXM * NYM * NZM + 1);
  localparam int PLANE_D = NXM * NYM;
  localparam logic [XW-1:0] NX_LIM = XW'(NXM);
  localparam logic [YW-1:0] NY_LIM = YW'(NYM);
  localparam logic [ZW-1:0] NZ_LIM = ZW'(NZM);

  cfg_t               cfg_r, cfg_nxt;
  logic               restart;
  logic               op_push, op_pop, op_full, op_empty;
  op_t                op_in, op_out;
  logic [FIFO_CW-1:0] op_cnt, res_cnt;
  logic               res_push, res_full;
  out_item_t          res_item;
  logic [XW-1:0]      wx;
  logic [YW-1:0]      wy;
  logic [ZW-1:0]      wz;

  // Register writes, with sizes clamped on the way in.
  always_comb begin
    wx      = cfg_data[XW-1:0];
    wy      = cfg_data[YW-1:0];
    wz      = cfg_data[ZW-1:0];
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_X_SIZE: begin
          cfg_nxt.nx = (wx == '0) ? XW'(1) : ((wx > NX_LIM) ? NX_LIM : wx);
          restart    = 1'b1;
        end
        REG_Y_SIZE: begin
          cfg_nxt.ny = (wy == '0) ? YW'(1) : ((wy > NY_LIM) ? NY_LIM : wy);
          restart    = 1'b1;
        end
        REG_Z_SIZE: begin
          cfg_nxt.nz = (wz == '0) ? ZW'(1) : ((wz > NZ_LIM) ? NZ_LIM : wz);
          restart    = 1'b1;
        end
        REG_IGNORE_ZERO: cfg_nxt.ignore_zero = cfg_data[0];
        REG_COUNT_OUTER: cfg_nxt.count_outer = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nx          <= (NX_LIM < XW'(256)) ? NX_LIM : XW'(256);
      cfg_r.ny          <= (NY_LIM < YW'(256)) ? NY_LIM : YW'(256);
      cfg_r.nz          <= (NZ_LIM < ZW'(256)) ? NZ_LIM : ZW'(256);
      cfg_r.ignore_zero <= 1'b1;
      cfg_r.count_outer <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vbnc_front #(.POS_W(POS_W)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .restart(restart),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .op_push(op_push), .op_item(op_in), .op_full(op_full)
  );

  vbnc_fifo #(.W($bits(op_t))) u_op_q (
    .clk(clk), .rst_n(rst_n), .push(op_push), .din(op_in), .pop(op_pop), .dout(op_out),
    .full(op_full), .empty(op_empty), .count(op_cnt)
  );

  vbnc_back #(.PLANE_D(PLANE_D), .ROW_D(NXM)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .restart(restart),
    .op_empty(op_empty), .op_pop(op_pop), .op_item(op_out),
    .res_push(res_push), .res_item(res_item), .res_cnt(res_cnt)
  );

  vbnc_fifo #(.W($bits(out_item_t))) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res_item), .pop(out_pop),
    .dout(out_item), .full(res_full), .empty(out_empty), .count(res_cnt)
  );

  // The back part's credit check must keep the result queue from overflowing.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result queue overflow");

  // The front part never writes a full op queue.
  a_op_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    op_push |-> !op_full) else $error("op queue overflow");

  // A size write holds the input off while the products settle.
  a_settle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> in_full) else $error("input taken during size settle");

  // Fill count and empty flag of the op queue agree.
  a_op_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    op_empty |-> (op_cnt == '0)) else $error("op queue count mismatch");

endmodule

>>> sv/vbnc_fifo.sv
module vbnc_fifo import vbnc_pkg::*; #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       din,
  input  logic               pop,
  output logic [W-1:0]       dout,
  output logic               full,
  output logic               empty,
  output logic [FIFO_CW-1:0] count
);

  localparam int AW = $clog2(FIFO_D);

  logic [W-1:0]       mem_r [FIFO_D];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == FIFO_CW'(FIFO_D));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> sv/vbnc_delay.sv
module vbnc_delay import vbnc_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int LW    = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  logic [IDW-1:0] din,
  input  logic [LW-1:0]  len,
  output logic [IDW-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [IDW-1:0] mem_r [DEPTH];
  logic [IDW-1:0] out_r;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [LW-1:0]  wrap_at;

  // A delay of len shifts: zero is a bypass, one a plain register, and
  // longer ones use a ring of len-1 entries ahead of the output register.
  assign wrap_at = len - LW'(2);
  assign dout    = (len == '0) ? din : out_r;

  always_comb begin
    if (LW'(ptr_r) >= wrap_at) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (shift && len > LW'(1)) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Ring storage with the read taken before the write at the same entry.
  always_ff @(posedge clk) begin
    if (shift) begin
      if (len <= LW'(1)) begin
        out_r <= din;
      end else begin
        out_r <= mem_r[ptr_r];
      end
      mem_r[ptr_r] <= din;
    end
  end

endmodule

>>> sv/vbnc_front.sv
module vbnc_front import vbnc_pkg::*; #(
  parameter int POS_W = 27
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     restart,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     op_push,
  output op_t      op_item,
  input  logic     op_full
);

  localparam int PW1 = POS_W + 1;
  localparam int PRW = PLANE_W + ZW;

  logic [PLANE_W-1:0] plane_r;
  logic [POS_W-1:0]   total_r;
  logic [PRW-1:0]     total_prod;
  logic [1:0]         settle_r;
  logic [POS_W-1:0]   in_pos_r, in_pos_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_last_r;
  logic [POS_W-1:0]   total_m1, need, rcv;
  logic [PW1-1:0]     need_raw;
  logic               store, due, last, extra, accept;

  // Plane and volume sizes follow the size registers through plane_r and then
  // total_r; the input is held off while they settle.
  assign total_prod = {{ZW{1'b0}}, plane_r} * {{PLANE_W{1'b0}}, cfg.nz};

  always_ff @(posedge clk) begin
    plane_r <= {{YW{1'b0}}, cfg.nx} * {{XW{1'b0}}, cfg.ny};
    total_r <= total_prod[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  // Classify the request: store it, answer a voxel, or both.
  always_comb begin
    total_m1 = total_r - POS_W'(1);
    store    = (in_item.kind == KIND_VOXEL) && (in_pos_r < total_r);
    rcv      = in_pos_r + POS_W'(store);
    need_raw = {1'b0, out_pos_r} + PW1'(plane_r);
    need     = (need_raw > {1'b0, total_m1}) ? total_m1 : need_raw[POS_W-1:0];
    due      = (need < rcv);
    last     = (out_pos_r == total_m1);
    // A single-plane volume needs one extra shift so the window lines up.
    extra    = due && store && (cfg.nz == ZW'(1));
    in_full  = op_full || pend_r || (settle_r != 2'd0);
    accept   = in_push && !in_full;
  end

  // Queue write toward the back part.
  always_comb begin
    op_push = (accept && (store || due)) || (pend_r && !op_full);
    if (pend_r) begin
      op_item.emit = 1'b1;
      op_item.last = pend_last_r;
      op_item.id   = '0;
    end else begin
      op_item.emit = due && !extra;
      op_item.last = last && !extra;
      op_item.id   = in_item.voxel_id;
    end
  end

  // Position bookkeeping for the volume in progress.
  always_comb begin
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    pend_nxt    = pend_r;
    if (pend_r && !op_full) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      in_pos_nxt = rcv;
      pend_nxt   = extra;
      if (due) begin
        if (last) begin
          in_pos_nxt  = '0;
          out_pos_nxt = '0;
        end else begin
          out_pos_nxt = out_pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_pos_r  <= '0;
      out_pos_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && extra) begin
      pend_last_r <= last;
    end
  end

endmodule

>>> sv/vbnc_back.sv
module vbnc_back import vbnc_pkg::*; #(
  parameter int PLANE_D = 65536,
  parameter int ROW_D   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               restart,
  input  logic               op_empty,
  output logic               op_pop,
  input  op_t                op_item,
  output logic               res_push,
  output out_item_t          res_item,
  input  logic [FIFO_CW-1:0] res_cnt
);

  logic [PLANE_W-1:0] plane_r, plane_gap;
  logic [XW-1:0]      row_gap;
  logic               shift;
  logic [IDW-1:0]     v0_r, tap_a, tap_b, c_r, d_r, tap_e, tap_f;
  logic [XW-1:0]      k_r, k_nxt;
  logic [YW-1:0]      j_r, j_nxt;
  logic [ZW-1:0]      i_r, i_nxt;
  logic               s1_v_r, s1_last_r;
  edge_flags_t        s1_edge_r, edge_now;
  logic [5:0]         hit;
  logic [2:0]         outer;
  logic [CNTW-1:0]    sum;

  always_ff @(posedge clk) begin
    plane_r <= {{YW{1'b0}}, cfg.nx} * {{XW{1'b0}}, cfg.ny};
  end

  assign plane_gap = plane_r - PLANE_W'(cfg.nx);
  assign row_gap   = cfg.nx - XW'(1);

  // One shift per queued op, as long as the result queue has room for it.
  assign shift  = !op_empty &&
                  ({1'b0, res_cnt} + {{FIFO_CW{1'b0}}, s1_v_r} < (FIFO_CW + 1)'(FIFO_D));
  assign op_pop = shift;

  // Neighbor window: newest tap is the voxel one plane ahead.
  always_ff @(posedge clk) begin
    if (shift) begin
      v0_r <= op_item.id;
      c_r  <= tap_b;
      d_r  <= c_r;
    end
  end

  vbnc_delay #(.DEPTH(PLANE_D), .LW(PLANE_W)) u_next_row (
    .clk(clk), .rst_n(rst_n), .shift(shift), .din(v0_r), .len(plane_gap), .dout(tap_a)
  );

  vbnc_delay #(.DEPTH(ROW_D), .LW(XW)) u_next_col (
    .clk(clk), .rst_n(rst_n), .shift(shift), .din(tap_a), .len(row_gap), .dout(tap_b)
  );

  vbnc_delay #(.DEPTH(ROW_D), .LW(XW)) u_prev_row (
    .clk(clk), .rst_n(rst_n), .shift(shift), .din(d_r), .len(row_gap), .dout(tap_e)
  );

  vbnc_delay #(.DEPTH(PLANE_D), .LW(PLANE_W)) u_prev_plane (
    .clk(clk), .rst_n(rst_n), .shift(shift), .din(tap_e), .len(plane_gap), .dout(tap_f)
  );

  // Coordinates of the next voxel to be answered.
  always_comb begin
    k_nxt = k_r;
    j_nxt = j_r;
    i_nxt = i_r;
    if (shift && op_item.emit) begin
      if (k_r >= cfg.nx - XW'(1)) begin
        k_nxt = '0;
        if (j_r >= cfg.ny - YW'(1)) begin
          j_nxt = '0;
          if (i_r >= cfg.nz - ZW'(1)) begin
            i_nxt = '0;
          end else begin
            i_nxt = i_r + ZW'(1);
          end
        end else begin
          j_nxt = j_r + YW'(1);
        end
      end else begin
        k_nxt = k_r + XW'(1);
      end
    end
    edge_now.x_lo = (k_r == '0);
    edge_now.x_hi = (k_r == cfg.nx - XW'(1));
    edge_now.y_lo = (j_r == '0);
    edge_now.y_hi = (j_r == cfg.ny - YW'(1));
    edge_now.z_lo = (i_r == '0);
    edge_now.z_hi = (i_r == cfg.nz - ZW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      k_r    <= '0;
      j_r    <= '0;
      i_r    <= '0;
      s1_v_r <= 1'b0;
    end else begin
      k_r    <= k_nxt;
      j_r    <= j_nxt;
      i_r    <= i_nxt;
      s1_v_r <= shift && op_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s1_edge_r <= edge_now;
      s1_last_r <= op_item.last;
    end
  end

  function automatic logic nb_counts(input logic [IDW-1:0] nb, input logic [IDW-1:0] self,
                                     input logic ign);
    nb_counts = (nb != self) && !nb[IDW-1] && (!ign || nb != '0);
  endfunction

  // Count differing neighbors and surface faces for the answered voxel.
  always_comb begin
    hit[0] = !s1_edge_r.z_lo && nb_counts(tap_f, c_r, cfg.ignore_zero);
    hit[1] = !s1_edge_r.y_lo && nb_counts(tap_e, c_r, cfg.ignore_zero);
    hit[2] = !s1_edge_r.x_lo && nb_counts(d_r, c_r, cfg.ignore_zero);
    hit[3] = !s1_edge_r.x_hi && nb_counts(tap_b, c_r, cfg.ignore_zero);
    hit[4] = !s1_edge_r.y_hi && nb_counts(tap_a, c_r, cfg.ignore_zero);
    hit[5] = !s1_edge_r.z_hi && nb_counts(v0_r, c_r, cfg.ignore_zero);
    outer[0] = (cfg.nx > XW'(2)) && (s1_edge_r.x_lo || s1_edge_r.x_hi);
    outer[1] = (cfg.ny > YW'(2)) && (s1_edge_r.y_lo || s1_edge_r.y_hi);
    outer[2] = (cfg.nz > ZW'(2)) && (s1_edge_r.z_lo || s1_edge_r.z_hi);
    if (!cfg.count_outer || c_r == '0) begin
      outer = '0;
    end
    sum = CNTW'(hit[0]) + CNTW'(hit[1]) + CNTW'(hit[2]) + CNTW'(hit[3]) +
          CNTW'(hit[4]) + CNTW'(hit[5]) +
          CNTW'(outer[0]) + CNTW'(outer[1]) + CNTW'(outer[2]);
    if (c_r[IDW-1]) begin
      sum = '0;
    end
    res_push                = s1_v_r;
    res_item.boundary_count = sum;
    res_item.last_of_volume = s1_last_r;
  end

endmodule
